FILE: design/fcr_pkg.sv
`default_nettype none

package fcr_pkg;

	localparam int FRAC_BITS = 16;

	localparam int K_W   = 20;
	localparam int F_W   = 28;
	localparam int C_W   = 28;
	localparam int XY_W  = 32;
	localparam int IDX_W = 3;
	localparam int CFG_W = 32;

	localparam logic [IDX_W-1:0] REG_LENS_K   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FOCAL_X  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y  = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd4;

	// Clamp a magnitude with a sign into the signed 32 bit range.
	function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
		logic [31:0] r;
		if (neg) begin
			r = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
		end else begin
			r = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/fisheye_coordinate_remap.sv
// Fisheye coordinate remap on the single-parameter Dhane lens model.
// A request on the input channel (in_valid/in_ready) carries cmd, coord_x and
// coord_y. With cmd 0 a distorted pixel is normalized and undistorted; with
// cmd 1 a normalized point is distorted and converted to pixels. Each request
// gives exactly one result on the output channel (out_valid/out_ready) with
// out_x, out_y and ok; ok is 0 outside the model domain and the coordinates
// are then 0. All coordinates are signed Q15.16 and results saturate.
// Registers are written over the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes belong to idle periods.
// The block takes one request per cycle while the receiver does not stall.
// A request passes through a chain of bit-per-stage square root and
// division pipelines (33, 32, 20, 20 and 33 stages).
// When the receiver stalls, the whole pipeline holds and in_ready drops
// until the waiting result is taken. Reset clears all valid bits and loads
// the register defaults: k and both focal lengths 1.0, center 0.

`default_nettype none

module fisheye_coordinate_remap
	import fcr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic signed [XY_W-1:0] coord_x,
	input  logic signed [XY_W-1:0] coord_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [XY_W-1:0] out_x,
	output logic signed [XY_W-1:0] out_y,
	output logic                   ok,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int NQ_W   = 33;
	localparam int OVF_SH = NQ_W - FRAC_BITS;
	localparam int D1_W   = 70;
	localparam int D2_W   = 68;
	localparam int D3_W   = 100;
	localparam int D4_W   = 121;
	localparam int D5_W   = 69;
	localparam logic [K_W-1:0] K_ONE  = K_W'(1) << FRAC_BITS;
	localparam logic [F_W-1:0] F_ONE  = F_W'(1) << FRAC_BITS;
	localparam logic [63:0]    ONE2   = 64'(1) << (2 * FRAC_BITS);
	localparam logic [39:0]    ONE2_S = 40'(1) << (2 * FRAC_BITS);
	localparam logic [48:0]    ONE3   = 49'(1) << (3 * FRAC_BITS);
	localparam logic [33:0]    LIM_DEN = 34'd10000;
	localparam logic [33:0]    LIM_NUM = 34'(9999) << FRAC_BITS;

	logic [K_W-1:0] lens_k_q;
	logic [F_W-1:0] focal_x_q;
	logic [F_W-1:0] focal_y_q;
	logic [C_W-1:0] center_x_q;
	logic [C_W-1:0] center_y_q;
	logic [39:0]    k2_q;
	logic           en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_k_q   <= K_ONE;
			focal_x_q  <= F_ONE;
			focal_y_q  <= F_ONE;
			center_x_q <= '0;
			center_y_q <= '0;
			k2_q       <= '0;
		end else begin
			k2_q <= 40'(lens_k_q) * 40'(lens_k_q);
			if (cfg_valid) begin
				case (cfg_index)
					REG_LENS_K:   lens_k_q   <= cfg_data[K_W-1:0];
					REG_FOCAL_X:  focal_x_q  <= cfg_data[F_W-1:0];
					REG_FOCAL_Y:  focal_y_q  <= cfg_data[F_W-1:0];
					REG_CENTER_X: center_x_q <= cfg_data[C_W-1:0];
					REG_CENTER_Y: center_y_q <= cfg_data[C_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Stage 1: offset from the center (cmd 0 only) and magnitude split.
	logic signed [33:0] base_x, base_y, dif_x, dif_y;
	logic        [33:0] abs_x, abs_y;
	logic               ovf_x, ovf_y;

	always_comb begin
		base_x = {{2{coord_x[31]}}, coord_x};
		base_y = {{2{coord_y[31]}}, coord_y};
		dif_x  = cmd ? base_x : base_x - $signed({6'b0, center_x_q});
		dif_y  = cmd ? base_y : base_y - $signed({6'b0, center_y_q});
		abs_x  = dif_x[33] ? 34'(-dif_x) : 34'(dif_x);
		abs_y  = dif_y[33] ? 34'(-dif_y) : 34'(dif_y);
		ovf_x  = !cmd && (45'(abs_x[32:0]) >= (45'(focal_x_q) << OVF_SH));
		ovf_y  = !cmd && (45'(abs_y[32:0]) >= (45'(focal_y_q) << OVF_SH));
	end

	logic        v_s1, cmd_s1, neg_x_s1, neg_y_s1, ovf_x_s1, ovf_y_s1;
	logic [32:0] mag_x_s1, mag_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= cmd;
			neg_x_s1 <= dif_x[33];
			neg_y_s1 <= dif_y[33];
			mag_x_s1 <= abs_x[32:0];
			mag_y_s1 <= abs_y[32:0];
			ovf_x_s1 <= ovf_x;
			ovf_y_s1 <= ovf_y;
		end
	end

	logic [NQ_W-1:0] nq_x, nq_y;

	fcr_div #(.NW(NQ_W + FRAC_BITS), .DW(F_W), .QW(NQ_W)) u_norm_x (
		.clk (clk),
		.en  (en),
		.num ({mag_x_s1, {FRAC_BITS{1'b0}}}),
		.den (focal_x_q),
		.quo (nq_x)
	);

	fcr_div #(.NW(NQ_W + FRAC_BITS), .DW(F_W), .QW(NQ_W)) u_norm_y (
		.clk (clk),
		.en  (en),
		.num ({mag_y_s1, {FRAC_BITS{1'b0}}}),
		.den (focal_y_q),
		.quo (nq_y)
	);

	logic [D1_W-1:0] d1;
	logic            d1_v, d1_cmd, d1_neg_x, d1_neg_y, d1_ovf_x, d1_ovf_y;
	logic [31:0]     d1_raw_x, d1_raw_y;

	fcr_dly #(.WIDTH(D1_W), .DEPTH(NQ_W)) u_dly1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({v_s1, cmd_s1, neg_x_s1, neg_y_s1, mag_x_s1[31:0], mag_y_s1[31:0],
			ovf_x_s1, ovf_y_s1}),
		.dout   (d1)
	);

	assign {d1_v, d1_cmd, d1_neg_x, d1_neg_y, d1_raw_x, d1_raw_y, d1_ovf_x, d1_ovf_y} = d1;

	// Stage 2: saturate the normalized point, or pass the raw point.
	logic [31:0] lim_x, lim_y, nm_x, nm_y;

	always_comb begin
		lim_x = d1_neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
		lim_y = d1_neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
		nm_x  = (d1_ovf_x || (nq_x > NQ_W'(lim_x))) ? lim_x : nq_x[31:0];
		nm_y  = (d1_ovf_y || (nq_y > NQ_W'(lim_y))) ? lim_y : nq_y[31:0];
	end

	logic        v_s2, cmd_s2, neg_x_s2, neg_y_s2;
	logic [31:0] mx_s2, my_s2;
	logic        v_s3, cmd_s3, neg_x_s3, neg_y_s3;
	logic [31:0] mx_s3, my_s3;
	logic [63:0] sq_x_s3, sq_y_s3;
	logic        v_s4, cmd_s4, neg_x_s4, neg_y_s4;
	logic [31:0] mx_s4, my_s4;
	logic [63:0] rs_s4, rp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= d1_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= d1_cmd;
			neg_x_s2 <= d1_neg_x;
			neg_y_s2 <= d1_neg_y;
			mx_s2    <= d1_cmd ? d1_raw_x : nm_x;
			my_s2    <= d1_cmd ? d1_raw_y : nm_y;

			cmd_s3   <= cmd_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			mx_s3    <= mx_s2;
			my_s3    <= my_s2;
			sq_x_s3  <= 64'(mx_s2) * 64'(mx_s2);
			sq_y_s3  <= 64'(my_s2) * 64'(my_s2);

			cmd_s4   <= cmd_s3;
			neg_x_s4 <= neg_x_s3;
			neg_y_s4 <= neg_y_s3;
			mx_s4    <= mx_s3;
			my_s4    <= my_s3;
			rs_s4    <= sq_x_s3 + sq_y_s3;
			rp_s4    <= sq_x_s3 + sq_y_s3 + ONE2;
		end
	end

	logic [31:0] rq, s1v;

	fcr_sqrt #(.W(32)) u_sqrt_r (
		.clk  (clk),
		.en   (en),
		.rad  (rs_s4),
		.root (rq)
	);

	fcr_sqrt #(.W(32)) u_sqrt_p (
		.clk  (clk),
		.en   (en),
		.rad  (rp_s4),
		.root (s1v)
	);

	logic [D2_W-1:0] d2;
	logic            d2_v, d2_cmd, d2_neg_x, d2_neg_y;
	logic [31:0]     d2_mx, d2_my;

	fcr_dly #(.WIDTH(D2_W), .DEPTH(32)) u_dly2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({v_s4, cmd_s4, neg_x_s4, neg_y_s4, mx_s4, my_s4}),
		.dout   (d2)
	);

	assign {d2_v, d2_cmd, d2_neg_x, d2_neg_y, d2_mx, d2_my} = d2;

	// Stage 5: radius products ahead of the three divisions by s1.
	logic        v_s5, cmd_s5, neg_x_s5, neg_y_s5;
	logic [31:0] mx_s5, my_s5, rq_s5, sd_s5;
	logic [51:0] kr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s5   <= d2_cmd;
			neg_x_s5 <= d2_neg_x;
			neg_y_s5 <= d2_neg_y;
			mx_s5    <= d2_mx;
			my_s5    <= d2_my;
			rq_s5    <= rq;
			sd_s5    <= s1v;
			kr_s5    <= 52'(lens_k_q) * 52'(rq);
		end
	end

	logic [K_W-1:0] q_in, q_a, q_b;

	fcr_div #(.NW(52), .DW(32), .QW(K_W)) u_div_inner (
		.clk (clk),
		.en  (en),
		.num (kr_s5),
		.den (sd_s5),
		.quo (q_in)
	);

	fcr_div #(.NW(52), .DW(32), .QW(K_W)) u_div_a (
		.clk (clk),
		.en  (en),
		.num (52'({lens_k_q, {FRAC_BITS{1'b0}}})),
		.den (sd_s5),
		.quo (q_a)
	);

	fcr_div #(.NW(52), .DW(32), .QW(K_W)) u_div_b (
		.clk (clk),
		.en  (en),
		.num (52'({rq_s5, {FRAC_BITS{1'b0}}})),
		.den (sd_s5),
		.quo (q_b)
	);

	logic [D3_W-1:0] d3;
	logic            d3_v, d3_cmd, d3_neg_x, d3_neg_y;
	logic [31:0]     d3_mx, d3_my, d3_sd;

	fcr_dly #(.WIDTH(D3_W), .DEPTH(K_W)) u_dly3 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({v_s5, cmd_s5, neg_x_s5, neg_y_s5, mx_s5, my_s5, sd_s5}),
		.dout   (d3)
	);

	assign {d3_v, d3_cmd, d3_neg_x, d3_neg_y, d3_mx, d3_my, d3_sd} = d3;

	// Stages 6 and 7: domain test and radicand for the second square root.
	logic           v_s6, cmd_s6, neg_x_s6, neg_y_s6, okc_s6;
	logic [31:0]    mx_s6, my_s6, sd_s6;
	logic [K_W-1:0] a_s6;
	logic [39:0]    sq_s6;
	logic [K_W-1:0] sq_sel;
	logic           v_s7, cmd_s7, neg_x_s7, neg_y_s7, ok_s7;
	logic [31:0]    mx_s7, my_s7, sd_s7;
	logic [K_W-1:0] a_s7;
	logic [39:0]    rad_s7;

	assign sq_sel = d3_cmd ? q_b : q_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= d3_v;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s6   <= d3_cmd;
			neg_x_s6 <= d3_neg_x;
			neg_y_s6 <= d3_neg_y;
			mx_s6    <= d3_mx;
			my_s6    <= d3_my;
			sd_s6    <= d3_sd;
			a_s6     <= q_a;
			sq_s6    <= 40'(sq_sel) * 40'(sq_sel);
			okc_s6   <= (34'(q_in) * LIM_DEN) <= LIM_NUM;

			cmd_s7   <= cmd_s6;
			neg_x_s7 <= neg_x_s6;
			neg_y_s7 <= neg_y_s6;
			mx_s7    <= mx_s6;
			my_s7    <= my_s6;
			sd_s7    <= sd_s6;
			a_s7     <= a_s6;
			rad_s7   <= cmd_s6 ? (k2_q - sq_s6) : (ONE2_S - sq_s6);
			ok_s7    <= cmd_s6 ? (k2_q > sq_s6) : okc_s6;
		end
	end

	logic [K_W-1:0] rt;

	fcr_sqrt #(.W(K_W)) u_sqrt_e (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s7),
		.root (rt)
	);

	logic [D4_W-1:0] d4;
	logic            d4_v, d4_cmd, d4_neg_x, d4_neg_y, d4_ok;
	logic [31:0]     d4_mx, d4_my, d4_sd;
	logic [K_W-1:0]  d4_a;

	fcr_dly #(.WIDTH(D4_W), .DEPTH(K_W)) u_dly4 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({v_s7, cmd_s7, neg_x_s7, neg_y_s7, mx_s7, my_s7, sd_s7, a_s7, ok_s7}),
		.dout   (d4)
	);

	assign {d4_v, d4_cmd, d4_neg_x, d4_neg_y, d4_mx, d4_my, d4_sd, d4_a, d4_ok} = d4;

	// Stage 8: operands of the shared factor division.
	logic        v_s8, cmd_s8, neg_x_s8, neg_y_s8, ok_s8;
	logic [31:0] mx_s8, my_s8;
	logic [48:0] num_s8;
	logic [51:0] den_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= d4_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s8   <= d4_cmd;
			neg_x_s8 <= d4_neg_x;
			neg_y_s8 <= d4_neg_y;
			mx_s8    <= d4_mx;
			my_s8    <= d4_my;
			ok_s8    <= d4_ok;
			num_s8   <= d4_cmd ? ONE3 : 49'({d4_a, {FRAC_BITS{1'b0}}});
			den_s8   <= d4_cmd ? (52'(d4_sd) * 52'(rt)) : 52'(rt);
		end
	end

	logic [NQ_W-1:0] fac;

	fcr_div #(.NW(49), .DW(52), .QW(NQ_W)) u_div_fac (
		.clk (clk),
		.en  (en),
		.num (num_s8),
		.den (den_s8),
		.quo (fac)
	);

	logic [D5_W-1:0] d5;
	logic            d5_v, d5_cmd, d5_neg_x, d5_neg_y, d5_ok;
	logic [31:0]     d5_mx, d5_my;

	fcr_dly #(.WIDTH(D5_W), .DEPTH(NQ_W)) u_dly5 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({v_s8, cmd_s8, neg_x_s8, neg_y_s8, mx_s8, my_s8, ok_s8}),
		.dout   (d5)
	);

	assign {d5_v, d5_cmd, d5_neg_x, d5_neg_y, d5_mx, d5_my, d5_ok} = d5;

	// Stages 9 to 11: scale, saturate, and for distortion scale to pixels.
	logic        v_s9, cmd_s9, neg_x_s9, neg_y_s9, ok_s9;
	logic [64:0] px_s9, py_s9;
	logic        v_s10, cmd_s10, ok_s10;
	logic [31:0] dx_s10, dy_s10;
	logic        v_s11, cmd_s11, ok_s11, nx_s11, ny_s11;
	logic [31:0] dx_s11, dy_s11;
	logic [59:0] pf_x_s11, pf_y_s11;
	logic [31:0] ax, ay;

	assign ax = dx_s10[31] ? (32'd0 - dx_s10) : dx_s10;
	assign ay = dy_s10[31] ? (32'd0 - dy_s10) : dy_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s9  <= d5_v;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s9   <= d5_cmd;
			neg_x_s9 <= d5_neg_x;
			neg_y_s9 <= d5_neg_y;
			ok_s9    <= d5_ok;
			px_s9    <= 65'(d5_mx) * 65'(fac);
			py_s9    <= 65'(d5_my) * 65'(fac);

			cmd_s10  <= cmd_s9;
			ok_s10   <= ok_s9;
			dx_s10   <= sat32(neg_x_s9, 64'(px_s9[64:FRAC_BITS]));
			dy_s10   <= sat32(neg_y_s9, 64'(py_s9[64:FRAC_BITS]));

			cmd_s11  <= cmd_s10;
			ok_s11   <= ok_s10;
			dx_s11   <= dx_s10;
			dy_s11   <= dy_s10;
			nx_s11   <= dx_s10[31];
			ny_s11   <= dy_s10[31];
			pf_x_s11 <= 60'(ax) * 60'(focal_x_q);
			pf_y_s11 <= 60'(ay) * 60'(focal_y_q);
		end
	end

	// Stage 12: for distortion add the center and saturate, then register the result.
	logic signed [45:0] pm_x, pm_y, sv_x, sv_y;
	logic        [45:0] sa_x, sa_y;
	logic        [31:0] pix_x, pix_y;
	logic               fz, okf;

	always_comb begin
		pm_x  = $signed({2'b0, pf_x_s11[59:FRAC_BITS]});
		pm_y  = $signed({2'b0, pf_y_s11[59:FRAC_BITS]});
		sv_x  = (nx_s11 ? -pm_x : pm_x) + $signed({18'b0, center_x_q});
		sv_y  = (ny_s11 ? -pm_y : pm_y) + $signed({18'b0, center_y_q});
		sa_x  = sv_x[45] ? 46'(-sv_x) : 46'(sv_x);
		sa_y  = sv_y[45] ? 46'(-sv_y) : 46'(sv_y);
		pix_x = sat32(sv_x[45], 64'(sa_x));
		pix_y = sat32(sv_y[45], 64'(sa_y));
		fz    = (focal_x_q == '0) || (focal_y_q == '0);
		okf   = cmd_s11 ? ok_s11 : (ok_s11 && !fz);
	end

	logic v_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok    <= okf;
			out_x <= !okf ? '0 : (cmd_s11 ? pix_x : dx_s11);
			out_y <= !okf ? '0 : (cmd_s11 ? pix_y : dy_s11);
		end
	end

	assign en        = !v_s12 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s12;

endmodule

`default_nettype wire

FILE: design/fcr_div.sv
`default_nettype none

module fcr_div #(
	parameter int NW = 52,
	parameter int DW = 32,
	parameter int QW = 20
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int CW = NW + DW + QW;

	logic [NW-1:0] rem_r [QW];
	logic [DW-1:0] den_r [QW];
	logic [QW-1:0] q_r   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int SH = QW - 1 - i;
		logic [NW-1:0] rin;
		logic [DW-1:0] din;
		logic [QW-1:0] qin;
		logic [CW-1:0] rem_x;
		logic [CW-1:0] trial;
		logic [CW-1:0] diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rin = num;
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_r[i-1];
			assign din = den_r[i-1];
			assign qin = q_r[i-1];
		end

		assign rem_x = CW'(rin);
		assign trial = CW'(din) << SH;
		assign ge    = rem_x >= trial;
		assign diff  = rem_x - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[i] <= ge ? diff[NW-1:0] : rin;
				den_r[i] <= din;
				q_r[i]   <= qin | (QW'(ge) << SH);
			end
		end
	end

	assign quo = q_r[QW-1];

endmodule

`default_nettype wire

FILE: design/fcr_sqrt.sv
`default_nettype none

module fcr_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] rad,
	output logic [W-1:0]   root
);

	localparam int RW = 2 * W + 1;

	logic [RW-1:0] v_r [W];
	logic [RW-1:0] r_r [W];

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int BP = 2 * (W - 1 - i);
		logic [RW-1:0] vin;
		logic [RW-1:0] rin;
		logic [RW-1:0] bitv;
		logic [RW-1:0] t;
		logic          ge;

		if (i == 0) begin : g_first
			assign vin = RW'(rad);
			assign rin = '0;
		end else begin : g_next
			assign vin = v_r[i-1];
			assign rin = r_r[i-1];
		end

		assign bitv = RW'(1) << BP;
		assign t    = rin + bitv;
		assign ge   = vin >= t;

		always_ff @(posedge clk) begin
			if (en) begin
				v_r[i] <= ge ? (vin - t) : vin;
				r_r[i] <= ge ? ((rin >> 1) + bitv) : (rin >> 1);
			end
		end
	end

	assign root = r_r[W-1][W-1:0];

endmodule

`default_nettype wire

FILE: design/fcr_dly.sv
`default_nettype none

module fcr_dly #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] sh_r [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				sh_r[i] <= '0;
			end
		end else if (en) begin
			sh_r[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				sh_r[i] <= sh_r[i-1];
			end
		end
	end

	assign dout = sh_r[DEPTH-1];

endmodule

`default_nettype wire

FILE: design/fcr_chk.sv
`default_nettype none

module fcr_chk
	import fcr_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic [XY_W-1:0] out_x,
	input wire logic [XY_W-1:0] out_y,
	input wire logic            ok
);

	// A result that waits for the receiver keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(ok))
		else $error("output changed while stalled");

	// A failed mapping reports zero coordinates.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> out_x == '0 && out_y == '0)
		else $error("failed mapping with nonzero coordinates");

	// New requests are taken exactly when the pipeline can move.
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output flow");

endmodule

bind fisheye_coordinate_remap fcr_chk u_fcr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.out_y     (out_y),
	.ok        (ok)
);

`default_nettype wire
